### hdl/dbnc_pkg.sv
// Shared constants and types for the multi-channel edge debouncer.
package dbnc_pkg;

    // Default sizing of the channel table and the timestamps
    localparam int DEF_CHANNELS  = 64;
    localparam int DEF_TIME_BITS = 32;

    // Fixed field widths on the streams
    localparam int CH_W = 6;
    localparam int TS_W = 32;

    // Input tdata layout: channel_index, raw_active, sample_time, zero fill
    localparam int IN_CH_LSB  = 0;
    localparam int IN_RAW_BIT = IN_CH_LSB + CH_W;
    localparam int IN_TS_LSB  = IN_RAW_BIT + 1;
    localparam int IN_DATA_W  = ((IN_TS_LSB + TS_W + 7) / 8) * 8;

    // Output tdata layout: event_channel, edge_res, zero fill
    localparam int OUT_CH_LSB   = 0;
    localparam int OUT_EDGE_BIT = OUT_CH_LSB + CH_W;
    localparam int OUT_DATA_W   = ((OUT_EDGE_BIT + 1 + 7) / 8) * 8;

    // Configuration port
    localparam int          CFG_AW         = 3;
    localparam int          CFG_DW         = 32;
    localparam logic        REG_CLICK      = 1'b0;
    localparam logic [31:0] CLICK_RST      = 32'd200;

    // Edge codes
    localparam logic EDGE_PRESS   = 1'b0;
    localparam logic EDGE_RELEASE = 1'b1;

    // Table update request from the qualifier to the channel store
    typedef struct packed {
        logic            press;
        logic            release_ev;
        logic [CH_W-1:0] ch;
    } t_wr_req;

endpackage

### hdl/multi_channel_edge_debouncer.sv
// Top level of the multi-channel edge debouncer.
//
// Samples arrive on the slave stream, one per request: channel index, raw level
// and timestamp in tdata, element kind in tuser. Each accepted sample yields at
// most one event on the master stream: channel and edge (press or release) in
// tdata, element kind in tuser. Samples with no qualified edge, and samples for
// channels at or above CHANNELS, produce nothing.
// An accepted sample passes the input register and then the output register,
// which holds its event. One sample can be accepted every cycle while the
// receiver does not stall. The timestamp memories are read in the accept cycle
// and written when the sample leaves the input register, with a same-channel
// write forwarded into the read data.
// When the receiver stalls, the output register holds its event and the input
// register holds the next sample, then tready drops. Reset clears all channel
// flags (every channel idle, no release seen), empties both registers and sets
// the click period to 200 ticks. The user must write the click period over the
// configuration port only while no sample is in flight; the block does not enforce it.
module multi_channel_edge_debouncer
    import dbnc_pkg::*;
#(
    parameter int CHANNELS  = DEF_CHANNELS,
    parameter int TIME_BITS = DEF_TIME_BITS
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [5:0] channel_index, [6] raw_active, [38:7] sample_time, rest zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] element_kind
    input  logic                  i_s_axis_tuser,
    // master stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [5:0] event_channel, [6] edge_res, rest zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // [0] event_kind
    output logic                  o_m_axis_tuser,
    // configuration
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_AW-1:0]     i_paddr,
    input  logic [CFG_DW-1:0]     i_pwdata,
    output logic [CFG_DW-1:0]     o_prdata,
    output logic                  o_pready
);

    logic [31:0]          click_period;
    logic                 in_accept;
    logic                 out_ready;
    logic                 s1_adv;
    logic [CH_W-1:0]      in_ch;
    logic                 in_range;
    logic                 active;
    logic                 seen;
    logic [TIME_BITS-1:0] press_time;
    logic [TIME_BITS-1:0] release_time;
    logic                 fire;
    logic                 edge_res;
    t_wr_req              wr;

    logic                 r_s1_valid;
    logic                 r_s1_in_range;
    logic [CH_W-1:0]      r_s1_ch;
    logic                 r_s1_kind;
    logic                 r_s1_raw;
    logic [TIME_BITS-1:0] r_s1_time;

    logic                 r_out_valid;
    logic [CH_W-1:0]      r_out_ch;
    logic                 r_out_kind;
    logic                 r_out_edge;

    dbnc_apb u_apb (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (i_psel),
        .i_penable      (i_penable),
        .i_pwrite       (i_pwrite),
        .i_paddr        (i_paddr),
        .i_pwdata       (i_pwdata),
        .o_prdata       (o_prdata),
        .o_pready       (o_pready),
        .o_click_period (click_period)
    );

    assign out_ready       = !r_out_valid || i_m_axis_tready;
    assign s1_adv          = r_s1_valid && out_ready;
    assign o_s_axis_tready = !r_s1_valid || out_ready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign in_ch           = i_s_axis_tdata[IN_CH_LSB +: CH_W];
    assign in_range        = 32'(in_ch) < 32'(CHANNELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_in_range <= in_range;
            r_s1_ch       <= in_ch;
            r_s1_kind     <= i_s_axis_tuser;
            r_s1_raw      <= i_s_axis_tdata[IN_RAW_BIT];
            r_s1_time     <= TIME_BITS'(i_s_axis_tdata[IN_TS_LSB +: TS_W]);
        end
    end

    dbnc_store #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS)
    ) u_store (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rd_en        (in_accept && in_range),
        .i_rd_ch        (in_ch),
        .i_cur_ch       (r_s1_ch),
        .i_wr           (wr),
        .i_wr_time      (r_s1_time),
        .o_active       (active),
        .o_seen         (seen),
        .o_press_time   (press_time),
        .o_release_time (release_time)
    );

    dbnc_judge #(
        .TIME_BITS (TIME_BITS)
    ) u_judge (
        .i_go           (s1_adv && r_s1_in_range),
        .i_ch           (r_s1_ch),
        .i_raw          (r_s1_raw),
        .i_now          (r_s1_time),
        .i_active       (active),
        .i_seen         (seen),
        .i_press_time   (press_time),
        .i_release_time (release_time),
        .i_click_period (click_period),
        .o_fire         (fire),
        .o_edge         (edge_res),
        .o_wr           (wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_ch   <= r_s1_ch;
            r_out_kind <= r_s1_kind;
            r_out_edge <= edge_res;
        end
    end

    always_comb begin
        o_m_axis_tdata                          = '0;
        o_m_axis_tdata[OUT_CH_LSB +: CH_W]      = r_out_ch;
        o_m_axis_tdata[OUT_EDGE_BIT]            = r_out_edge;
    end
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;

`ifndef ASSERT_OFF
    // A held sample keeps its channel until it can move on.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_ready) |=> (r_s1_valid && $stable(r_s1_ch)))
        else $error("input register lost a stalled sample");

    // A sample for a channel outside the table never produces an event.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && !r_s1_in_range) |=> !o_m_axis_tvalid)
        else $error("event produced for an out-of-range channel");

    // One sample updates either the press or the release side, never both.
    a_one_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr.press && wr.release_ev))
        else $error("press and release written together");

    // A new event only appears when a sample left the input register.
    a_event_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(s1_adv))
        else $error("event appeared without a sample");
`endif

endmodule

### hdl/dbnc_apb.sv
// Configuration register port holding the click period.
module dbnc_apb
    import dbnc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [CFG_AW-1:0] i_paddr,
    input  logic [CFG_DW-1:0] i_pwdata,
    output logic [CFG_DW-1:0] o_prdata,
    output logic              o_pready,
    output logic [31:0]       o_click_period
);

    logic [31:0] r_click;
    logic        wr_hit;

    // Word index sits at bit 2 of the byte address.
    assign wr_hit = i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_CLICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_click <= CLICK_RST;
        end else if (wr_hit) begin
            r_click <= i_pwdata;
        end
    end

    assign o_pready       = 1'b1;
    assign o_prdata       = (i_paddr[2] == REG_CLICK) ? r_click : '0;
    assign o_click_period = r_click;

endmodule

### hdl/dbnc_store.sv
// Per-channel state: level flags in flip-flops, timestamps in memories.
module dbnc_store
    import dbnc_pkg::*;
#(
    parameter int CHANNELS  = DEF_CHANNELS,
    parameter int TIME_BITS = DEF_TIME_BITS
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [CH_W-1:0]      i_rd_ch,
    input  logic [CH_W-1:0]      i_cur_ch,
    input  t_wr_req              i_wr,
    input  logic [TIME_BITS-1:0] i_wr_time,
    output logic                 o_active,
    output logic                 o_seen,
    output logic [TIME_BITS-1:0] o_press_time,
    output logic [TIME_BITS-1:0] o_release_time
);

    // Only the channels reachable through the index field are stored.
    localparam int DEPTH = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DEPTH-1:0]     r_active;
    logic [DEPTH-1:0]     r_seen;
    logic [TIME_BITS-1:0] press_mem   [DEPTH];
    logic [TIME_BITS-1:0] release_mem [DEPTH];
    logic [TIME_BITS-1:0] r_press_rd;
    logic [TIME_BITS-1:0] r_release_rd;
    logic [AW-1:0]        rd_idx;
    logic [AW-1:0]        wr_idx;
    logic [AW-1:0]        cur_idx;
    logic                 cur_ok;

    assign rd_idx  = i_rd_ch[AW-1:0];
    assign wr_idx  = i_wr.ch[AW-1:0];
    assign cur_idx = i_cur_ch[AW-1:0];
    assign cur_ok  = 32'(i_cur_ch) < 32'(DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_seen   <= '0;
        end else if (i_wr.press) begin
            r_active[wr_idx] <= 1'b1;
        end else if (i_wr.release_ev) begin
            r_active[wr_idx] <= 1'b0;
            r_seen[wr_idx]   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.press) begin
            press_mem[wr_idx] <= i_wr_time;
        end
        if (i_wr.release_ev) begin
            release_mem[wr_idx] <= i_wr_time;
        end
    end

    // A write to the channel being read in the same cycle is forwarded, so that
    // back-to-back samples of one channel see the newest timestamp.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_press_rd   <= (i_wr.press && (wr_idx == rd_idx)) ?
                            i_wr_time : press_mem[rd_idx];
            r_release_rd <= (i_wr.release_ev && (wr_idx == rd_idx)) ?
                            i_wr_time : release_mem[rd_idx];
        end
    end

    assign o_active       = cur_ok ? r_active[cur_idx] : 1'b0;
    assign o_seen         = cur_ok ? r_seen[cur_idx]   : 1'b0;
    assign o_press_time   = r_press_rd;
    assign o_release_time = r_release_rd;

endmodule

### hdl/dbnc_judge.sv
// Edge qualification: decides whether a sample is an accepted press or release.
module dbnc_judge
    import dbnc_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS
)
(
    input  logic                 i_go,
    input  logic [CH_W-1:0]      i_ch,
    input  logic                 i_raw,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic                 i_active,
    input  logic                 i_seen,
    input  logic [TIME_BITS-1:0] i_press_time,
    input  logic [TIME_BITS-1:0] i_release_time,
    input  logic [31:0]          i_click_period,
    output logic                 o_fire,
    output logic                 o_edge,
    output t_wr_req              o_wr
);

    localparam int CW = (TIME_BITS > 31) ? TIME_BITS : 31;

    logic [TIME_BITS-1:0] since_press;
    logic [TIME_BITS-1:0] since_release;
    logic [CW-1:0]        half_period;
    logic                 press_long;
    logic                 release_long;
    logic                 press_ok;
    logic                 release_ok;

    // Twice the elapsed time exceeds the period exactly when the elapsed time
    // exceeds the period halved and rounded down.
    assign since_press   = i_now - i_press_time;
    assign since_release = i_now - i_release_time;
    assign half_period   = CW'(i_click_period[31:1]);
    assign press_long    = CW'(since_press)   > half_period;
    assign release_long  = CW'(since_release) > half_period;

    assign press_ok   = !i_active && i_raw && (!i_seen || release_long);
    assign release_ok = i_active && !i_raw && press_long;

    assign o_wr.press      = i_go && press_ok;
    assign o_wr.release_ev = i_go && release_ok;
    assign o_wr.ch         = i_ch;
    assign o_fire          = o_wr.press || o_wr.release_ev;
    assign o_edge          = i_active ? EDGE_RELEASE : EDGE_PRESS;

endmodule
